[design/tcw_pkg.sv]
// Shared types and constants for the text console writer.
// Used by tcw_engine and text_console_writer; depends on nothing.
package tcw_pkg;

    localparam int DEF_SCREEN_WIDTH  = 80;
    localparam int DEF_SCREEN_HEIGHT = 25;

    localparam int REQ_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 8;
    localparam int CELL_W    = 16;
    localparam int IN_ROW_W  = 5;
    localparam int IN_COL_W  = 7;
    localparam int OUT_ROW_W = 5;
    localparam int OUT_COL_W = 7;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BKSP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'h0A;
    localparam logic [CHAR_W-1:0]  CH_TAB      = 8'h09;
    localparam int                 TAB_EXTRA   = 5;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;
    localparam logic [CELL_W-1:0]  CELL_RESET  = {COLOR_RESET, CH_SPACE};

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [CHAR_W-1:0]   char_code;
        logic [IN_ROW_W-1:0] read_row;
        logic [IN_COL_W-1:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [CELL_W-1:0]    read_cell;
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [OUT_COL_W-1:0] cursor_col;
        logic                 scrolled;
    } t_out_item;

endpackage

[design/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/tcw_engine.sv]
// Request sequencer: cursor, shared cell address unit, clear and scroll sweeps.
// Depends on tcw_pkg; drives the frame store ports of one tcw_ram.
module tcw_engine import tcw_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    localparam int CELLS        = SCREEN_WIDTH * SCREEN_HEIGHT,
    localparam int ADDR_W       = $clog2(CELLS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  t_in_item            i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output t_out_item           o_out_data,
    input  logic                i_out_stall,
    input  logic [COLOR_W-1:0]  i_text_color,
    output logic                o_ram_we,
    output logic [ADDR_W-1:0]   o_ram_waddr,
    output logic [CELL_W-1:0]   o_ram_wdata,
    output logic [ADDR_W-1:0]   o_ram_raddr,
    input  logic [CELL_W-1:0]   i_ram_rdata
);

    localparam int ROW_W = $clog2(SCREEN_HEIGHT);
    localparam int COL_W = $clog2(SCREEN_WIDTH);
    localparam int CW1   = COL_W + 1;
    localparam int IDX_W = $clog2(CELLS + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCROLL
    } t_state;

    t_state             r_state, n_state;
    t_in_item           r_req, n_req;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_cp_valid, n_cp_valid;
    logic               r_cp_zero, n_cp_zero;
    logic [ADDR_W-1:0]  r_cp_addr, n_cp_addr;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               in_acc;
    logic [CW1-1:0]     col_inc, col_tab;
    logic [ROW_W:0]     row_inc;
    logic [COL_W-1:0]   bk_col;
    logic               is_nl, is_tab, wrap;
    logic [CHAR_W-1:0]  stored;
    logic [31:0]        a_row, a_col, a_sum;
    logic [ADDR_W-1:0]  acc_addr, src_addr;
    logic               rd_hit;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall));

    // cursor arithmetic
    assign is_nl   = (r_req.char_code == CH_NEWLINE);
    assign is_tab  = (r_req.char_code == CH_TAB);
    assign stored  = (is_nl || is_tab) ? CH_SPACE : r_req.char_code;
    assign col_inc = {1'b0, r_col} + CW1'(1);
    assign col_tab = col_inc + CW1'(TAB_EXTRA);
    assign row_inc = {1'b0, r_row} + (ROW_W + 1)'(1);
    assign bk_col  = (r_col != '0) ? (r_col - COL_W'(1)) : '0;
    assign wrap    = (col_inc >= CW1'(SCREEN_WIDTH)) || is_nl
                     || (is_tab && (col_tab >= CW1'(SCREEN_WIDTH)));

    // shared address unit: row * width + column
    always_comb begin
        case (r_req.req_type)
            REQ_READ: begin
                a_row = 32'(r_req.read_row);
                a_col = 32'(r_req.read_col);
            end
            REQ_BKSP: begin
                a_row = 32'(r_row);
                a_col = 32'(bk_col);
            end
            default: begin
                a_row = 32'(r_row);
                a_col = 32'(r_col);
            end
        endcase
    end

    assign a_sum    = a_row * 32'(SCREEN_WIDTH) + a_col;
    assign acc_addr = a_sum[ADDR_W-1:0];
    assign rd_hit   = (32'(r_req.read_row) < 32'(SCREEN_HEIGHT))
                      && (32'(r_req.read_col) < 32'(SCREEN_WIDTH));
    assign src_addr = ADDR_W'(r_idx + IDX_W'(SCREEN_WIDTH));

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_row       = r_row;
        n_col       = r_col;
        n_idx       = r_idx;
        n_cp_valid  = 1'b0;
        n_cp_zero   = r_cp_zero;
        n_cp_addr   = r_cp_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_ram_we    = 1'b0;
        o_ram_waddr = acc_addr;
        o_ram_wdata = {i_text_color, stored};
        o_ram_raddr = (r_state == S_SCROLL) ? src_addr : acc_addr;

        case (r_state)
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx[ADDR_W-1:0];
                o_ram_wdata = CELL_RESET;
                if (r_idx == IDX_W'(CELLS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_req   = i_in_data;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state              = S_IDLE;
                n_out.read_cell      = '0;
                n_out.scrolled       = 1'b0;
                case (r_req.req_type)
                    REQ_PUT: begin
                        o_ram_we = 1'b1;
                        if (wrap) begin
                            n_col = '0;
                            if (row_inc >= (ROW_W + 1)'(SCREEN_HEIGHT)) begin
                                n_row   = ROW_W'(SCREEN_HEIGHT - 1);
                                n_idx   = '0;
                                n_state = S_SCROLL;
                            end else begin
                                n_row = row_inc[ROW_W-1:0];
                            end
                        end else begin
                            n_col = is_tab ? col_tab[COL_W-1:0] : col_inc[COL_W-1:0];
                        end
                    end
                    REQ_BKSP: begin
                        o_ram_we    = 1'b1;
                        o_ram_wdata = {i_text_color, CH_SPACE};
                        n_col       = bk_col;
                    end
                    REQ_READ: begin
                        if (rd_hit) begin
                            n_state = S_READ;
                        end
                    end
                    default: begin
                    end
                endcase
                if (n_state == S_IDLE) begin
                    n_out_valid = 1'b1;
                end
            end
            S_READ: begin
                n_out_valid     = 1'b1;
                n_out.read_cell = i_ram_rdata;
                n_state         = S_IDLE;
            end
            S_SCROLL: begin
                // dest cell r_idx: copy from one row down, zero on the bottom row;
                // the write lands in the next cycle, together with the read data
                o_ram_we    = r_cp_valid;
                o_ram_waddr = r_cp_addr;
                o_ram_wdata = r_cp_zero ? '0 : i_ram_rdata;
                if (r_idx == IDX_W'(CELLS)) begin
                    n_idx          = '0;
                    n_state        = S_IDLE;
                    n_out_valid    = 1'b1;
                    n_out.scrolled = 1'b1;
                end else begin
                    n_cp_valid = 1'b1;
                    n_cp_zero  = (r_idx >= IDX_W'(CELLS - SCREEN_WIDTH));
                    n_cp_addr  = r_idx[ADDR_W-1:0];
                    n_idx      = r_idx + IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out.cursor_row = OUT_ROW_W'(32'(n_row));
        n_out.cursor_col = OUT_COL_W'(32'(n_col));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_col       <= '0;
            r_idx       <= '0;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_idx       <= n_idx;
            r_cp_valid  <= n_cp_valid;
            r_out_valid <= n_out_valid;
            r_req       <= n_req;
            r_cp_zero   <= n_cp_zero;
            r_cp_addr   <= n_cp_addr;
            r_out       <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(SCREEN_WIDTH))
        else $error("cursor column beyond screen width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < 32'(SCREEN_HEIGHT))
        else $error("cursor row beyond screen height");

    a_copy_in_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_valid |-> (r_state == S_SCROLL))
        else $error("scroll copy pending outside scroll");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC) && !r_out_valid)
        else $error("accepted request not executed or result slot busy");

    a_no_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result during clearing pass");

endmodule

[design/text_console_writer.sv]
// Text console writer top level: color register, sequencer and frame store.
// Depends on tcw_pkg, tcw_engine and tcw_ram.
//
// Usage:
//   Input channel (i_in_valid / i_in_data / o_in_stall) takes one request per
//   transfer: put character, backspace or read one cell. Every request gives
//   exactly one result on the output channel (o_out_valid / o_out_data /
//   i_out_stall): the read cell (zero unless a read hit the screen), the
//   cursor after the request and a scroll flag.
//   Config channel (i_cfg_valid / i_cfg_data / o_cfg_ready) writes the color
//   byte for new cells; it is always ready and must only be used while idle.
// Timing:
//   A request is taken one transfer at a time. Put, backspace and misses
//   pass S_EXEC into the result register; a read hit passes S_EXEC and
//   S_READ (registered RAM read). A put that wraps past the bottom row
//   scrolls: the sequencer sweeps every cell through the RAM's read and
//   write ports. After reset a clearing pass fills every cell of the store
//   with grey-on-black spaces; o_in_stall is high during it.
//   A result waiting under i_out_stall holds; the next request is taken in
//   the cycle that result transfers.
module text_console_writer import tcw_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_item          o_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_valid,
    input  logic [COLOR_W-1:0] i_cfg_data,
    output logic               o_cfg_ready
);

    localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);

    logic [COLOR_W-1:0] r_text_color;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= COLOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_text_color <= i_cfg_data;
        end
    end

    tcw_engine #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall),
        .i_text_color (r_text_color),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
